/* hw/rtl/lcsd_pkg.sv */
// ----------------------------------------------------------------------------
// lcsd_pkg
// Shared types and constants for the lidar corner spike detector.
// ----------------------------------------------------------------------------
package lcsd_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int DATA_W          = 16;   // width of filtered result fields
   localparam int CALC_W          = 18;   // signed width for difference and range compares
   localparam int HIST_DEPTH      = 3;
   localparam int THR_W           = 10;
   localparam int PERSIST_W       = 8;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 10;

   localparam logic [THR_W-1:0]     THRESHOLD_RST = 10'd100;
   localparam logic [PERSIST_W-1:0] PERSIST_RST   = 8'd5;
   localparam logic [THR_W-1:0]     VALID_MIN_RST = 10'd2;
   localparam logic [THR_W-1:0]     VALID_MAX_RST = 10'd600;

   localparam logic [1:0] FILL_FULL = 2'd3;
   localparam logic [1:0] SLOT_LAST = 2'd2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_JUMP_LIMIT      = 2'd0,
      CSR_PERSIST_COUNT   = 2'd1,
      CSR_VALID_MIN       = 2'd2,
      CSR_VALID_MAX       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_RIGHT = 2'd2
   } dir_type;

   typedef struct packed {
      logic [THR_W-1:0]     jump_limit;
      logic [PERSIST_W-1:0] persist_count;
      logic [THR_W-1:0]     valid_min;
      logic [THR_W-1:0]     valid_max;
   } cfg_type;

   typedef struct packed {
      logic turn_detected;
      logic turn_left;
      logic layout_locked;
      logic locked_left;
   } flags_type;

endpackage

/* hw/rtl/lcsd_median.sv */
// ----------------------------------------------------------------------------
// lcsd_median
// Median-of-three filter for one channel; first three samples pass through.
// ----------------------------------------------------------------------------
module lcsd_median #(
   parameter int SAMPLE_BITS = lcsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] filtered
);

   logic signed [SAMPLE_BITS-1:0] hist_ff [lcsd_pkg::HIST_DEPTH];
   logic signed [SAMPLE_BITS-1:0] hist_in [lcsd_pkg::HIST_DEPTH];
   logic [1:0] fill_ff, fill_in;
   logic [1:0] slot_ff, slot_in;
   logic signed [SAMPLE_BITS-1:0] lo_ab, hi_ab, hi_c, med;

   always_comb begin
      hist_in = hist_ff;
      hist_in[slot_ff] = sample;
      slot_in = (slot_ff == lcsd_pkg::SLOT_LAST) ? 2'd0 : slot_ff + 2'd1;
      fill_in = (fill_ff == lcsd_pkg::FILL_FULL) ? fill_ff : fill_ff + 2'd1;
   end

   // median = max(min(a,b), min(max(a,b),c))
   always_comb begin
      lo_ab = (hist_in[0] < hist_in[1]) ? hist_in[0] : hist_in[1];
      hi_ab = (hist_in[0] < hist_in[1]) ? hist_in[1] : hist_in[0];
      hi_c  = (hi_ab < hist_in[2]) ? hi_ab : hist_in[2];
      med   = (lo_ab < hi_c) ? hi_c : lo_ab;
   end

   assign filtered = (fill_ff == lcsd_pkg::FILL_FULL) ? med : sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         slot_ff <= 2'd0;
      end else if (step) begin
         fill_ff <= fill_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         hist_ff <= hist_in;
      end
   end

endmodule

/* hw/rtl/lcsd_corner.sv */
// ----------------------------------------------------------------------------
// lcsd_corner
// Spike streak tracking, corner confirmation and direction lock.
// ----------------------------------------------------------------------------
module lcsd_corner #(
   parameter int SAMPLE_BITS = lcsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic signed [SAMPLE_BITS-1:0] fl,
   input  logic signed [SAMPLE_BITS-1:0] fr,
   input  logic                          check_enabled,
   input  logic                          cooldown_active,
   input  lcsd_pkg::cfg_type             cfg,
   output lcsd_pkg::flags_type           flags
);

   logic [lcsd_pkg::PERSIST_W-1:0] streak_ff, streak_in, streak_inc;
   lcsd_pkg::dir_type              dir_ff, dir_in, dir_new;
   logic                           turned_ff, turned_in;
   logic                           lock_left_ff, lock_left_in;

   logic signed [lcsd_pkg::CALC_W-1:0] l_ext, r_ext, diff, thr, vmin, vmax;
   logic in_range, sl, sr, detected;

   always_comb begin
      l_ext = lcsd_pkg::CALC_W'(fl);
      r_ext = lcsd_pkg::CALC_W'(fr);
      diff  = l_ext - r_ext;
      thr   = signed'(lcsd_pkg::CALC_W'(cfg.jump_limit));
      vmin  = signed'(lcsd_pkg::CALC_W'(cfg.valid_min));
      vmax  = signed'(lcsd_pkg::CALC_W'(cfg.valid_max));
      in_range = (l_ext >= vmin) && (l_ext <= vmax) && (r_ext >= vmin) && (r_ext <= vmax);
      sl = (diff > thr)  && !(turned_ff && !lock_left_ff);
      sr = (diff < -thr) && !(turned_ff && lock_left_ff);
      dir_new = sl ? lcsd_pkg::DIR_LEFT : lcsd_pkg::DIR_RIGHT;
      // a direction change restarts the streak
      streak_inc = ((dir_new != dir_ff) ? '0 : streak_ff) + lcsd_pkg::PERSIST_W'(1);
   end

   always_comb begin
      streak_in    = streak_ff;
      dir_in       = dir_ff;
      turned_in    = turned_ff;
      lock_left_in = lock_left_ff;
      detected     = 1'b0;
      if (check_enabled) begin
         if (cooldown_active || !in_range || (!sl && !sr)) begin
            streak_in = '0;
         end else begin
            dir_in = dir_new;
            if (streak_inc >= cfg.persist_count) begin
               streak_in = '0;
               detected  = 1'b1;
               if (!turned_ff) begin
                  turned_in    = 1'b1;
                  lock_left_in = sl;
               end
            end else begin
               streak_in = streak_inc;
            end
         end
      end
      flags.turn_detected = detected;
      flags.turn_left     = detected && sl;
      flags.layout_locked = turned_in;
      flags.locked_left   = lock_left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         streak_ff    <= '0;
         dir_ff       <= lcsd_pkg::DIR_NONE;
         turned_ff    <= 1'b0;
         lock_left_ff <= 1'b0;
      end else if (step) begin
         streak_ff    <= streak_in;
         dir_ff       <= dir_in;
         turned_ff    <= turned_in;
         lock_left_ff <= lock_left_in;
      end
   end

endmodule

/* hw/rtl/lidar_corner_spike_detector.sv */
// ----------------------------------------------------------------------------
// lidar_corner_spike_detector
// Path: input register, then result register once it is free or being read.
// Throughput: one request per cycle while responses are taken; the filter and
// streak state update in the single compute stage between the two registers,
// so items follow back to back.
// Reset: synchronous; config returns to 100/5/2/600, filters and streak clear.
// ----------------------------------------------------------------------------
module lidar_corner_spike_detector #(
   parameter int SAMPLE_BITS = lcsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // raw_left, raw_right
   input  logic [1:0]                        req_tuser,  // check_enabled, cooldown_active
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // filtered_left, filtered_right
   output logic [3:0]                        rsp_tuser,  // turn_detected, turn_left,
                                                         // layout_locked, locked_left
   input  logic                              csr_wen,
   input  logic [lcsd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [lcsd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   lcsd_pkg::cfg_type cfg_ff;

   logic                          in_vld_ff;
   logic signed [SAMPLE_BITS-1:0] in_left_ff, in_right_ff;
   logic                          in_check_ff, in_cool_ff;
   logic                          out_vld_ff;
   logic signed [lcsd_pkg::DATA_W-1:0] out_left_ff, out_right_ff;
   lcsd_pkg::flags_type           out_flags_ff;

   logic                          advance;
   logic signed [SAMPLE_BITS-1:0] fl, fr;
   lcsd_pkg::flags_type           flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jump_limit    <= lcsd_pkg::THRESHOLD_RST;
         cfg_ff.persist_count <= lcsd_pkg::PERSIST_RST;
         cfg_ff.valid_min     <= lcsd_pkg::VALID_MIN_RST;
         cfg_ff.valid_max     <= lcsd_pkg::VALID_MAX_RST;
      end else if (csr_wen) begin
         unique case (lcsd_pkg::csr_index_type'(csr_addr))
            lcsd_pkg::CSR_JUMP_LIMIT:      cfg_ff.jump_limit <= csr_wdata;
            lcsd_pkg::CSR_PERSIST_COUNT:
               cfg_ff.persist_count <= csr_wdata[lcsd_pkg::PERSIST_W-1:0];
            lcsd_pkg::CSR_VALID_MIN:       cfg_ff.valid_min <= csr_wdata;
            lcsd_pkg::CSR_VALID_MAX:       cfg_ff.valid_max <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_left_ff  <= req_tdata[SAMPLE_BITS-1:0];
         in_right_ff <= req_tdata[16 +: SAMPLE_BITS];
         in_check_ff <= req_tuser[0];
         in_cool_ff  <= req_tuser[1];
      end
      if (advance) begin
         out_left_ff  <= lcsd_pkg::DATA_W'(fl);
         out_right_ff <= lcsd_pkg::DATA_W'(fr);
         out_flags_ff <= flags;
      end
   end

   lcsd_median #(.SAMPLE_BITS(SAMPLE_BITS)) u_med_left (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .sample   (in_left_ff),
      .filtered (fl)
   );

   lcsd_median #(.SAMPLE_BITS(SAMPLE_BITS)) u_med_right (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .sample   (in_right_ff),
      .filtered (fr)
   );

   lcsd_corner #(.SAMPLE_BITS(SAMPLE_BITS)) u_corner (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .fl              (fl),
      .fr              (fr),
      .check_enabled   (in_check_ff),
      .cooldown_active (in_cool_ff),
      .cfg             (cfg_ff),
      .flags           (flags)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_right_ff, out_left_ff};
   assign rsp_tuser  = {out_flags_ff.locked_left, out_flags_ff.layout_locked,
                        out_flags_ff.turn_left, out_flags_ff.turn_detected};

   // a confirmed turn always leaves the layout locked
   a_detect_locks: assert property (@(posedge clock) disable iff (reset)
      advance && flags.turn_detected |-> flags.layout_locked)
      else $error("turn confirmed without layout lock");

   // once locked, the lock never drops until reset
   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      advance && flags.layout_locked |=> flags.layout_locked)
      else $error("layout lock dropped");

   // a turn direction is only reported with a detected turn
   a_left_needs_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_flags_ff.turn_left |-> out_flags_ff.turn_detected)
      else $error("turn_left without turn_detected");

endmodule

/* tb/tb_lidar_corner_spike_detector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lidar_corner_spike_detector
// Streams left/right range samples through the corner detector and checks each
// filtered response and its turn flags against an in-bench model of the two
// median filters, the spike streak and the one-time direction lock. The run
// steps through several register settings, extremes included, with random
// stalls on both channels in most settings.
// ----------------------------------------------------------------------------
module tb_lidar_corner_spike_detector;

   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               turn_detected;
      logic               turn_left;
      logic               layout_locked;
      logic               locked_left;
   } reading_type;

   class spike_tracker_type;
      lcsd_pkg::cfg_type  cfg;
      logic signed [15:0] hist [2][3];
      logic [1:0]         fill [2];
      logic [1:0]         slot [2];
      logic [7:0]         streak;
      lcsd_pkg::dir_type  last_dir;
      logic               turned;
      logic               lock_left;
      reading_type        awaited [$];
      int                 checked;
      int                 turns;
      int                 failures;

      function new();
         cfg.jump_limit      = lcsd_pkg::THRESHOLD_RST;
         cfg.persist_count   = lcsd_pkg::PERSIST_RST;
         cfg.valid_min       = lcsd_pkg::VALID_MIN_RST;
         cfg.valid_max       = lcsd_pkg::VALID_MAX_RST;
         for (int ch = 0; ch < 2; ch++) begin
            for (int i = 0; i < 3; i++) hist[ch][i] = '0;
            fill[ch] = '0;
            slot[ch] = '0;
         end
         streak    = '0;
         last_dir  = lcsd_pkg::DIR_NONE;
         turned    = 1'b0;
         lock_left = 1'b0;
         checked   = 0;
         turns     = 0;
         failures  = 0;
      endfunction

      function void set_register(lcsd_pkg::csr_index_type idx,
                                 logic [lcsd_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            lcsd_pkg::CSR_JUMP_LIMIT:    cfg.jump_limit    = value;
            lcsd_pkg::CSR_PERSIST_COUNT: cfg.persist_count = value[lcsd_pkg::PERSIST_W-1:0];
            lcsd_pkg::CSR_VALID_MIN:     cfg.valid_min     = value;
            lcsd_pkg::CSR_VALID_MAX:     cfg.valid_max     = value;
            default: ;
         endcase
      endfunction

      // first three samples of a channel pass straight through
      function logic signed [15:0] median_push(int ch, logic signed [15:0] v);
         int a, b, c, lo, hi;
         hist[ch][slot[ch]] = v;
         slot[ch] = (slot[ch] == lcsd_pkg::SLOT_LAST) ? 2'd0 : slot[ch] + 2'd1;
         if (fill[ch] != lcsd_pkg::FILL_FULL) begin
            fill[ch] = fill[ch] + 2'd1;
            return v;
         end
         a  = hist[ch][0];
         b  = hist[ch][1];
         c  = hist[ch][2];
         lo = (a < b) ? a : b;
         lo = (lo < c) ? lo : c;
         hi = (a > b) ? a : b;
         hi = (hi > c) ? hi : c;
         return 16'(a + b + c - lo - hi);
      endfunction

      function bit wall_ok(logic signed [15:0] d);
         return int'(d) >= int'(cfg.valid_min) && int'(d) <= int'(cfg.valid_max);
      endfunction

      function void take_samples(logic [31:0] data, logic [1:0] user);
         reading_type       r;
         logic              sl, sr, hit, go_left;
         int                diff, thr;
         lcsd_pkg::dir_type dir;
         r.left  = median_push(0, data[15:0]);
         r.right = median_push(1, data[31:16]);
         hit     = 1'b0;
         go_left = 1'b0;
         if (user[0]) begin
            if (user[1] || !wall_ok(r.left) || !wall_ok(r.right)) begin
               streak = '0;
            end else begin
               diff = int'(r.left) - int'(r.right);
               thr  = int'(cfg.jump_limit);
               sl   = diff > thr;
               sr   = diff < -thr;
               // once locked, a spike toward the other side is ignored
               if (turned) begin
                  if (lock_left) sr = 1'b0;
                  else sl = 1'b0;
               end
               if (!sl && !sr) begin
                  streak = '0;
               end else begin
                  dir = sl ? lcsd_pkg::DIR_LEFT : lcsd_pkg::DIR_RIGHT;
                  if (dir != last_dir) streak = '0;
                  last_dir = dir;
                  streak   = streak + 8'd1;
                  // persist count of zero confirms on every spike
                  if (streak >= cfg.persist_count) begin
                     streak  = '0;
                     hit     = 1'b1;
                     go_left = sl;
                     if (!turned) begin
                        turned    = 1'b1;
                        lock_left = sl;
                     end
                  end
               end
            end
         end
         r.turn_detected = hit;
         r.turn_left     = hit && go_left;
         r.layout_locked = turned;
         r.locked_left   = lock_left;
         awaited.push_back(r);
      endfunction

      function void check_result(logic [31:0] data, logic [3:0] user);
         reading_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: L=%0d R=%0d flags=%b", $signed(data[15:0]),
                        $signed(data[31:16]), user);
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (want.turn_detected) turns++;
         if (data[15:0] !== want.left || data[31:16] !== want.right ||
             user[0] !== want.turn_detected || user[1] !== want.turn_left ||
             user[2] !== want.layout_locked || user[3] !== want.locked_left) begin
            failures++;
            // flags in order det/left/lock/lkl
            if (failures <= 10)
               $display("mismatch #%0d: exp L/R=%0d/%0d %b%b%b%b got L/R=%0d/%0d %b%b%b%b",
                        checked, want.left, want.right, want.turn_detected, want.turn_left,
                        want.layout_locked, want.locked_left, $signed(data[15:0]),
                        $signed(data[31:16]), user[0], user[1], user[2], user[3]);
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [31:0]                     req_tdata;   // raw_left, raw_right
   logic [1:0]                      req_tuser;   // check_enabled, cooldown_active
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [31:0]                     rsp_tdata;   // filtered_left, filtered_right
   logic [3:0]                      rsp_tuser;   // turn_detected, turn_left, layout_locked,
                                                 // locked_left
   logic                            csr_wen;
   logic [lcsd_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [lcsd_pkg::CSR_DATA_W-1:0] csr_wdata;

   spike_tracker_type tracker;
   logic              send_gaps;
   logic              recv_gaps;
   int                sent = 0;
   int                quiet_cycles = 0;

   lidar_corner_spike_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic send_request(logic signed [15:0] left, logic signed [15:0] right,
                               logic chk, logic cool);
      int gap;
      gap = send_gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      req_tuser  <= {cool, chk};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_samples({right, left}, {cool, chk});
      sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(lcsd_pkg::csr_index_type idx,
                            logic [lcsd_pkg::CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   task automatic set_config(logic [lcsd_pkg::CSR_DATA_W-1:0] thr,
                             logic [lcsd_pkg::CSR_DATA_W-1:0] persist,
                             logic [lcsd_pkg::CSR_DATA_W-1:0] vmin,
                             logic [lcsd_pkg::CSR_DATA_W-1:0] vmax);
      write_reg(lcsd_pkg::CSR_JUMP_LIMIT, thr);
      write_reg(lcsd_pkg::CSR_PERSIST_COUNT, persist);
      write_reg(lcsd_pkg::CSR_VALID_MIN, vmin);
      write_reg(lcsd_pkg::CSR_VALID_MAX, vmax);
      csr_wen <= 1'b0;
   endtask

   // wall on both sides with one side stepping away by the threshold or more
   task automatic spike_run(logic go_left, int len, logic clean);
      int                 base, delta, jit;
      logic signed [15:0] lo, hi;
      logic               chk, cool;
      base = $urandom_range(0, 700);
      case ($urandom_range(0, 3))
         0: delta = int'(tracker.cfg.jump_limit);   // right at threshold, no spike
         1: delta = int'(tracker.cfg.jump_limit) + 1;
         default: delta = int'(tracker.cfg.jump_limit) + $urandom_range(1, 300);
      endcase
      if (clean) delta = int'(tracker.cfg.jump_limit) + $urandom_range(1, 50);
      for (int j = 0; j < len; j++) begin
         jit  = $urandom_range(0, 3);
         lo   = 16'(base + jit);
         hi   = 16'(base + delta + jit);
         chk  = clean || ($urandom_range(0, 19) != 0);
         cool = !clean && ($urandom_range(0, 24) == 0);
         if (go_left) send_request(hi, lo, chk, cool);
         else send_request(lo, hi, chk, cool);
      end
   endtask

   task automatic random_phase(int n);
      int done, lim, len, kind, base;
      done = 0;
      while (done < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            lim = int'(tracker.cfg.persist_count) + 2;
            if (lim > 12) lim = 12;
            len = $urandom_range(1, lim);
            spike_run(1'($urandom_range(0, 1)), len, 1'b0);
            done += len;
         end else if (kind < 80) begin
            base = $urandom_range(0, 1023);
            send_request(16'(base), 16'(base + $urandom_range(0, 50)),
                         $urandom_range(0, 7) != 0, 1'b0);
            done++;
         end else begin
            send_request(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
            done++;
         end
      end
   endtask

   // response side: random back-pressure per response
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = recv_gaps ? $urandom_range(0, 14) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         tracker.check_result(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_lidar_corner_spike_detector: errors");
         $finish;
      end
   end

   initial begin
      logic               flip;
      logic signed [15:0] far_cm, near_cm;
      int                 settings;
      tracker    = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      csr_wen    <= 1'b0;
      csr_addr   <= lcsd_pkg::CSR_JUMP_LIMIT;
      csr_wdata  <= '0;
      send_gaps  = 1'b1;
      recv_gaps  = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part on reset settings; lock direction picked at random
      settings = 1;
      flip     = 1'($urandom_range(0, 1));
      far_cm   = 16'sd400;
      near_cm  = 16'sd100;
      send_request(16'sh8000, 16'sd32767, 1'b1, 1'b0);
      send_request(16'sd32767, 16'sh8000, 1'b1, 1'b0);
      send_request(-16'sd1, -16'sd1, 1'b1, 1'b0);       // read failure on both
      send_request(16'sd0, 16'sd0, 1'b1, 1'b0);
      send_request(16'sd300, 16'sd300, 1'b0, 1'b0);     // filter only
      repeat (3) send_request(flip ? far_cm : near_cm, flip ? near_cm : far_cm, 1'b1, 1'b0);
      send_request(flip ? far_cm : near_cm, flip ? near_cm : far_cm, 1'b1, 1'b1);
      // turn the other way: streak restarts, then confirms and locks
      repeat (7) send_request(flip ? near_cm : far_cm, flip ? far_cm : near_cm, 1'b1, 1'b0);
      repeat (3) send_request(flip ? far_cm : near_cm, flip ? near_cm : far_cm, 1'b1, 1'b0);
      repeat (2) send_request(16'sd700, 16'sd100, 1'b1, 1'b0);
      repeat (2) send_request(16'sd1, 16'sd100, 1'b1, 1'b0);
      wait_drained();

      // zero threshold, single-spike confirm, full range, no idling
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      set_config(10'd0, 10'd1, 10'd0, 10'd1023);
      settings++;
      random_phase(60);
      wait_drained();   // sender holds off until every response is back
      random_phase(60);
      wait_drained();

      // empty valid window, top threshold and persist
      send_gaps = $urandom_range(0, 3) != 0;
      recv_gaps = $urandom_range(0, 3) != 0;
      set_config(10'd1023, 10'd255, 10'd1023, 10'd0);
      settings++;
      random_phase(60);
      wait_drained();

      // long clean run in the locked direction to reach a 255-long streak
      send_gaps = 1'b1;
      recv_gaps = 1'($urandom_range(0, 1));
      set_config(10'd20, 10'd255, 10'd0, 10'd1023);
      settings++;
      spike_run(tracker.lock_left, 258, 1'b1);
      random_phase(30);
      wait_drained();

      // persist count of zero
      send_gaps = $urandom_range(0, 3) != 0;
      recv_gaps = $urandom_range(0, 3) != 0;
      set_config(10'd100, 10'd0, 10'd2, 10'd600);
      settings++;
      random_phase(100);
      wait_drained();

      repeat (3) begin
         send_gaps = $urandom_range(0, 3) != 0;
         recv_gaps = $urandom_range(0, 3) != 0;
         set_config(10'($urandom_range(0, 400)), 10'($urandom_range(1, 8)),
                    10'($urandom_range(0, 50)), 10'($urandom_range(500, 1023)));
         settings++;
         random_phase(60);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      tracker.failures += tracker.awaited.size();
      $display("run: %0d requests under %0d register settings, %0d responses checked",
               sent, settings, tracker.checked);
      $display("run: %0d corners confirmed, layout locked to the %s",
               tracker.turns, tracker.lock_left ? "left" : "right");
      if (tracker.failures == 0)
         $display("tb_lidar_corner_spike_detector: clean");
      else
         $display("tb_lidar_corner_spike_detector: errors");
      $finish;
   end

endmodule
